// ----- rtl/wait_queue_with_missed_wakeups_defines.svh -----
// Assertion macros for the wait queue block.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef WAIT_QUEUE_WITH_MISSED_WAKEUPS_DEFINES_SVH
`define WAIT_QUEUE_WITH_MISSED_WAKEUPS_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define WQMW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define WQMW_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WQMW_ASSERT(lbl, prop, msg)
`define WQMW_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ----- rtl/wqmw_pkg.sv -----
// Shared types and codes of the wait queue block.
// No dependencies.
package wqmw_pkg;

  localparam int unsigned DEF_QUEUE_DEPTH    = 16;
  localparam int unsigned DEF_WAITER_ID_BITS = 6;
  localparam int unsigned DEF_MISSED_BITS    = 16;

  typedef logic [1:0] op_t;
  localparam op_t OP_SLEEP    = 2'd0;
  localparam op_t OP_WAKE_ONE = 2'd1;
  localparam op_t OP_WAKE_ALL = 2'd2;
  localparam op_t OP_INTR     = 2'd3;

  typedef logic [2:0] status_t;
  localparam status_t ST_TOOK       = 3'd0;
  localparam status_t ST_WOULDBLOCK = 3'd1;
  localparam status_t ST_QUEUED     = 3'd2;
  localparam status_t ST_FULL       = 3'd3;
  localparam status_t ST_WOKEN      = 3'd4;
  localparam status_t ST_NONE       = 3'd5;
  localparam status_t ST_INTR       = 3'd6;
  localparam status_t ST_NOTINTR    = 3'd7;

  // Control broadcast to every cell of the queue.
  typedef struct packed {
    logic load;   // write the new entry into the cell at the occupancy index
    logic shift;  // every cell takes its right neighbor
    logic rec;    // with shift: the tail cell takes the head entry instead
  } cell_ctl_t;

endpackage

// ----- rtl/wait_queue_with_missed_wakeups.sv -----
// Wait queue: sleep, wake one, wake all and interrupt, with missed-wakeup count.
// Sleep, wake one and empty-queue items give their registered result in the
// cycle after acceptance; a new item is taken at that edge if the output is free.
// Wake all gives one result per cycle per waiter while the output is free, set
// by the head cell shifting. Interrupt rotates the cell chain once, then answers.
// Synchronous active-low reset empties the queue and clears the missed count.
module wait_queue_with_missed_wakeups #(
  parameter int unsigned QUEUE_DEPTH    = wqmw_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned WAITER_ID_BITS = wqmw_pkg::DEF_WAITER_ID_BITS,
  parameter int unsigned MISSED_BITS    = wqmw_pkg::DEF_MISSED_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  wqmw_pkg::op_t             in_operation,
  input  logic [WAITER_ID_BITS-1:0] in_waiter_id,
  input  logic                      in_nonblock,
  input  logic                      in_interruptible,
  output logic                      out_valid,
  input  logic                      out_stall,
  output wqmw_pkg::status_t         out_status,
  output logic [WAITER_ID_BITS-1:0] out_woken_id,
  output logic                      out_last,
  output logic                      out_queue_empty
);
  import wqmw_pkg::*;

  `include "wait_queue_with_missed_wakeups_defines.svh"

  localparam int unsigned OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [MISSED_BITS-1:0] MISSED_MAX = {MISSED_BITS{1'b1}};

  typedef enum logic [1:0] {S_IDLE, S_WALL, S_INTR, S_IRES} state_t;

  state_t                   state_r, state_nxt;
  logic [OCC_W-1:0]         occ_r, occ_nxt;
  logic [OCC_W-1:0]         cnt_r, cnt_nxt;
  logic [MISSED_BITS-1:0]   missed_r, missed_nxt;
  logic                     en_r;
  logic                     found_r, found_nxt;
  logic                     hit_r, hit_nxt;
  logic [WAITER_ID_BITS-1:0] tid_r, tid_nxt;

  logic                      out_valid_r;
  status_t                   out_status_r;
  logic [WAITER_ID_BITS-1:0] out_id_r;
  logic                      out_last_r;
  logic                      out_empty_r;

  logic                      emit;
  status_t                   e_status;
  logic [WAITER_ID_BITS-1:0] e_id;
  logic                      e_last;

  cell_ctl_t                 ctl;
  logic [WAITER_ID_BITS-1:0] cell_id [QUEUE_DEPTH];
  logic                      cell_intr [QUEUE_DEPTH];
  logic                      free, accept, match, drop;

  assign free      = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !free;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign match = !found_r && (cell_id[0] == tid_r);
  assign drop  = match && cell_intr[0];

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    if (g < QUEUE_DEPTH - 1) begin : g_mid
      wqmw_cell #(.IDX(g), .DEPTH(QUEUE_DEPTH), .ID_W(WAITER_ID_BITS)) u_cell (
        .clk, .ctl, .occ(occ_r),
        .new_id(in_waiter_id), .new_intr(in_interruptible),
        .head_id(cell_id[0]), .head_intr(cell_intr[0]),
        .nbr_id(cell_id[g+1]), .nbr_intr(cell_intr[g+1]),
        .id_q(cell_id[g]), .intr_q(cell_intr[g])
      );
    end else begin : g_end
      // The last cell has no right neighbor; what it takes on a shift is never read.
      wqmw_cell #(.IDX(g), .DEPTH(QUEUE_DEPTH), .ID_W(WAITER_ID_BITS)) u_cell (
        .clk, .ctl, .occ(occ_r),
        .new_id(in_waiter_id), .new_intr(in_interruptible),
        .head_id(cell_id[0]), .head_intr(cell_intr[0]),
        .nbr_id(cell_id[g]), .nbr_intr(cell_intr[g]),
        .id_q(cell_id[g]), .intr_q(cell_intr[g])
      );
    end
  end

  always_comb begin
    state_nxt  = state_r;
    occ_nxt    = occ_r;
    cnt_nxt    = cnt_r;
    missed_nxt = missed_r;
    found_nxt  = found_r;
    hit_nxt    = hit_r;
    tid_nxt    = tid_r;
    ctl        = '0;
    emit       = 1'b0;
    e_status   = ST_NONE;
    e_id       = '0;
    e_last     = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_operation)
            OP_SLEEP: begin
              emit = 1'b1;
              if (en_r && missed_r != '0) begin
                missed_nxt = missed_r - 1'b1;
                e_status   = ST_TOOK;
              end else if (en_r && in_nonblock) begin
                e_status = ST_WOULDBLOCK;
              end else if (occ_r == OCC_W'(QUEUE_DEPTH)) begin
                e_status = ST_FULL;
              end else begin
                ctl.load = 1'b1;
                occ_nxt  = occ_r + 1'b1;
                e_status = ST_QUEUED;
              end
            end
            OP_WAKE_ONE: begin
              emit = 1'b1;
              if (occ_r != '0) begin
                ctl.shift = 1'b1;
                occ_nxt   = occ_r - 1'b1;
                e_status  = ST_WOKEN;
                e_id      = cell_id[0];
              end else begin
                if (en_r && missed_r != MISSED_MAX) missed_nxt = missed_r + 1'b1;
                e_status = ST_NONE;
              end
            end
            OP_WAKE_ALL: begin
              if (occ_r == '0) begin
                emit     = 1'b1;
                e_status = ST_NONE;
              end else begin
                state_nxt = S_WALL;
              end
            end
            OP_INTR: begin
              if (occ_r == '0) begin
                emit     = 1'b1;
                e_status = ST_NOTINTR;
              end else begin
                tid_nxt   = in_waiter_id;
                cnt_nxt   = occ_r;
                found_nxt = 1'b0;
                hit_nxt   = 1'b0;
                state_nxt = S_INTR;
              end
            end
            default: ;
          endcase
        end
      end
      S_WALL: begin
        if (free) begin
          ctl.shift = 1'b1;
          occ_nxt   = occ_r - 1'b1;
          emit      = 1'b1;
          e_status  = ST_WOKEN;
          e_id      = cell_id[0];
          e_last    = (occ_r == OCC_W'(1));
          if (occ_r == OCC_W'(1)) state_nxt = S_IDLE;
        end
      end
      S_INTR: begin
        // The head leaves each cycle and is recirculated to the tail unless it
        // is the first match and interruptible; a full pass keeps the order.
        ctl.shift = 1'b1;
        ctl.rec   = !drop;
        if (drop) begin
          occ_nxt = occ_r - 1'b1;
          hit_nxt = 1'b1;
        end
        found_nxt = found_r || match;
        cnt_nxt   = cnt_r - 1'b1;
        if (cnt_r == OCC_W'(1)) state_nxt = S_IRES;
      end
      S_IRES: begin
        if (free) begin
          emit      = 1'b1;
          e_status  = hit_r ? ST_INTR : ST_NOTINTR;
          e_id      = hit_r ? tid_r : '0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      cnt_r       <= '0;
      missed_r    <= '0;
      en_r        <= 1'b0;
      found_r     <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      occ_r    <= occ_nxt;
      cnt_r    <= cnt_nxt;
      missed_r <= missed_nxt;
      found_r  <= found_nxt;
      hit_r    <= hit_nxt;
      if (cfg_valid && cfg_ready) en_r <= cfg_data;
      if (emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    tid_r <= tid_nxt;
    if (emit) begin
      out_status_r <= e_status;
      out_id_r     <= e_id;
      out_last_r   <= e_last;
      out_empty_r  <= (occ_nxt == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_woken_id    = out_id_r;
  assign out_last        = out_last_r;
  assign out_queue_empty = out_empty_r;

  `WQMW_ASSERT_RST(a_occ_bound, !rst_n || (occ_r <= OCC_W'(QUEUE_DEPTH)), "occupancy above depth")
  `WQMW_ASSERT(a_busy_stalls, (state_r != S_IDLE) |-> in_stall, "input taken while busy")
  `WQMW_ASSERT(a_wall_nonempty, (state_r == S_WALL) |-> (occ_r != '0), "wake all on empty queue")
  `WQMW_ASSERT(a_missed_idle, !$stable(missed_r) |-> $past(state_r == S_IDLE && accept),
               "missed count changed outside an accepted item")

endmodule

// ----- rtl/wqmw_cell.sv -----
// One queue slot: holds a waiter identifier and its interruptible mark.
// Depends on wqmw_pkg for the control struct.
module wqmw_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned DEPTH = wqmw_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned ID_W  = wqmw_pkg::DEF_WAITER_ID_BITS
) (
  input  logic                       clk,
  input  wqmw_pkg::cell_ctl_t        ctl,
  input  logic [$clog2(DEPTH+1)-1:0] occ,
  input  logic [ID_W-1:0]            new_id,
  input  logic                       new_intr,
  input  logic [ID_W-1:0]            head_id,
  input  logic                       head_intr,
  input  logic [ID_W-1:0]            nbr_id,
  input  logic                       nbr_intr,
  output logic [ID_W-1:0]            id_q,
  output logic                       intr_q
);
  import wqmw_pkg::*;

  localparam int unsigned OCC_W = $clog2(DEPTH + 1);

  logic [ID_W-1:0] id_r, id_nxt;
  logic            intr_r, intr_nxt;

  always_comb begin
    id_nxt   = id_r;
    intr_nxt = intr_r;
    if (ctl.load && occ == OCC_W'(IDX)) begin
      id_nxt   = new_id;
      intr_nxt = new_intr;
    end else if (ctl.shift) begin
      // The tail cell sits at occupancy minus one.
      if (ctl.rec && occ == OCC_W'(IDX + 1)) begin
        id_nxt   = head_id;
        intr_nxt = head_intr;
      end else begin
        id_nxt   = nbr_id;
        intr_nxt = nbr_intr;
      end
    end
  end

  always_ff @(posedge clk) begin
    id_r   <= id_nxt;
    intr_r <= intr_nxt;
  end

  assign id_q   = id_r;
  assign intr_q = intr_r;

endmodule
